// ----- hw/rtl/dpr_pkg.sv -----
// Package for the debug packet receiver: phase and event codes, marker bytes
// and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package dpr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_DIG1 = 2'd2,
    PH_DIG2 = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_GOOD    = 3'd2,
    EV_BAD     = 3'd3,
    EV_INTR    = 3'd4
  } event_e;

  localparam logic [7:0] StartMark     = 8'h24;
  localparam logic [7:0] EndMark       = 8'h23;
  localparam logic [7:0] InterruptByte = 8'h03;
  localparam logic [7:0] NackByte      = 8'h2d;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    logic [7:0] t;
    r = '{ok: 1'b0, nib: 4'd0};
    t = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
      r = '{ok: 1'b1, nib: t[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
      r = '{ok: 1'b1, nib: t[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
      r = '{ok: 1'b1, nib: t[3:0]};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/debug_packet_receiver_core.sv -----
// Debug packet receiver top level: input register, parse logic, result register.
// Depends on dpr_pkg.
`timescale 1ns / 1ps

// Receives '$' body '#' hex hex packets one byte per item and gives exactly one
// result item per byte: nothing, a payload byte, packet good, checksum bad
// (answer with '-'), or an interrupt for 0x03 outside a packet. An item passes
// an input register and a result register, and a new byte is taken every cycle
// while results are drained; the phase, sum and nibble registers update as each
// byte leaves the input register.
module debug_packet_receiver_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_res_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] sent_sum_o,
  output logic [7:0] computed_sum_o
);

  logic             in_vld_q;
  logic [7:0]       in_byte_q;
  logic             out_vld_q;
  dpr_pkg::event_e  ev_q, ev_d;
  logic [7:0]       pay_q, pay_d, sent_q, sent_d, comp_q, comp_d;

  dpr_pkg::phase_e  phase_q, phase_d;
  logic [7:0]       sum_q, sum_d;
  logic [3:0]       hi_q, hi_d;
  logic             derr_q, derr_d;

  logic             out_free, s1_free, s1_fire;
  dpr_pkg::hex_t    hx;

  assign out_free   = !out_vld_q || out_ready_i;
  assign s1_fire    = in_vld_q && out_free;
  assign s1_free    = !in_vld_q || out_free;
  assign in_ready_o = s1_free;

  always_comb begin
    hx      = dpr_pkg::hex_decode(in_byte_q);
    phase_d = phase_q;
    sum_d   = sum_q;
    hi_d    = hi_q;
    derr_d  = derr_q;
    ev_d    = dpr_pkg::EV_NONE;
    pay_d   = 8'd0;
    sent_d  = 8'd0;
    comp_d  = 8'd0;
    case (phase_q)
      dpr_pkg::PH_HUNT: begin
        if (in_byte_q == dpr_pkg::StartMark) begin
          phase_d = dpr_pkg::PH_BODY;
          sum_d   = 8'd0;
          hi_d    = 4'd0;
          derr_d  = 1'b0;
        end else if (in_byte_q == dpr_pkg::InterruptByte) begin
          ev_d = dpr_pkg::EV_INTR;
        end
      end
      dpr_pkg::PH_BODY: begin
        if (in_byte_q == dpr_pkg::EndMark) begin
          phase_d = dpr_pkg::PH_DIG1;
        end else begin
          sum_d = sum_q + in_byte_q;
          ev_d  = dpr_pkg::EV_PAYLOAD;
          pay_d = in_byte_q;
        end
      end
      dpr_pkg::PH_DIG1: begin
        hi_d    = hx.nib;
        derr_d  = !hx.ok;
        phase_d = dpr_pkg::PH_DIG2;
      end
      default: begin
        sent_d  = {hi_q, hx.nib};
        comp_d  = sum_q;
        ev_d    = (hx.ok && !derr_q && (sent_d == sum_q)) ? dpr_pkg::EV_GOOD
                                                          : dpr_pkg::EV_BAD;
        phase_d = dpr_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= dpr_pkg::PH_HUNT;
      sum_q     <= 8'd0;
      hi_q      <= 4'd0;
      derr_q    <= 1'b0;
    end else begin
      if (s1_free) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (s1_fire) begin
        phase_q <= phase_d;
        sum_q   <= sum_d;
        hi_q    <= hi_d;
        derr_q  <= derr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
    if (s1_fire) begin
      ev_q   <= ev_d;
      pay_q  <= pay_d;
      sent_q <= sent_d;
      comp_q <= comp_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign event_res_o    = ev_q;
  assign payload_byte_o = pay_q;
  assign sent_sum_o     = sent_q;
  assign computed_sum_o = comp_q;

  a_good_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && ev_q == dpr_pkg::EV_GOOD) |-> (sent_q == comp_q))
    else $error("good packet reported with mismatched sums");

  a_payload_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && ev_q != dpr_pkg::EV_PAYLOAD) |-> (pay_q == 8'd0))
    else $error("payload byte set on non-payload event");

  a_dig2_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && phase_q == dpr_pkg::PH_DIG2) |=>
      (phase_q == dpr_pkg::PH_HUNT && out_vld_q &&
       (ev_q == dpr_pkg::EV_GOOD || ev_q == dpr_pkg::EV_BAD)))
    else $error("second checksum digit did not close the packet");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_free) |=> out_vld_q)
    else $error("item lost between input and result register");

endmodule

// ----- tb/debug_packet_receiver_core_tb.sv -----
// Testbench for debug_packet_receiver_core: queued byte driver, result monitor and a
// packet parser predictor checked item by item. Depends on dpr_pkg and the core.
`timescale 1ns / 1ps

module debug_packet_receiver_core_tb;
  import dpr_pkg::*;

  typedef struct {
    event_e     ev;
    logic [7:0] payload;
    logic [7:0] sent;
    logic [7:0] computed;
  } rx_result_t;

  localparam int NumBytes = 1050;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] event_res_o;
  logic [7:0] payload_byte_o;
  logic [7:0] sent_sum_o;
  logic [7:0] computed_sum_o;

  logic [7:0] byte_q[$];
  bit         drain_q[$];
  rx_result_t expected_q[$];

  int sent_cnt = 0;
  int recv_cnt = 0;
  int err_cnt = 0;
  int good_cnt = 0;
  int nack_cnt = 0;
  int intr_cnt = 0;
  int payload_cnt = 0;

  // predictor state
  phase_e     rx_phase = PH_HUNT;
  logic [7:0] rx_sum = 8'h00;
  logic [3:0] rx_high = 4'h0;
  logic       rx_digit_err = 1'b0;

  debug_packet_receiver_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_o   (event_res_o),
    .payload_byte_o(payload_byte_o),
    .sent_sum_o    (sent_sum_o),
    .computed_sum_o(computed_sum_o)
  );

  always #2 clk_i = ~clk_i;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  function automatic int idle_pct(input bit sender);
    if (sent_cnt < 350) return sender ? 8 : 48;
    if (sent_cnt < 700) return sender ? 48 : 8;
    return 0;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    rx_result_t r;
    logic [4:0] d;
    r = '{ev: EV_NONE, payload: 8'h00, sent: 8'h00, computed: 8'h00};
    d = hex_digit_value(b);
    case (rx_phase)
      PH_HUNT: begin
        if (b == StartMark) begin
          rx_phase = PH_BODY;
          rx_sum = 8'h00;
          rx_high = 4'h0;
          rx_digit_err = 1'b0;
        end else if (b == InterruptByte) begin
          r.ev = EV_INTR;
        end
      end
      PH_BODY: begin
        if (b == EndMark) begin
          rx_phase = PH_DIG1;
        end else begin
          rx_sum = rx_sum + b;
          r.ev = EV_PAYLOAD;
          r.payload = b;
        end
      end
      PH_DIG1: begin
        rx_high = d[3:0];
        rx_digit_err = !d[4];
        rx_phase = PH_DIG2;
      end
      default: begin
        r.sent = {rx_high, d[3:0]};
        r.computed = rx_sum;
        r.ev = (d[4] && !rx_digit_err && r.sent == rx_sum) ? EV_GOOD : EV_BAD;
        rx_phase = PH_HUNT;
      end
    endcase
    expected_q.push_back(r);
  endtask

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  // stimulus helpers
  task automatic add_byte(input logic [7:0] b, input bit hold = 1'b0);
    byte_q.push_back(b);
    drain_q.push_back(hold);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] b;
    logic [4:0] d;
    case ($urandom_range(0, 3))
      0: b = StartMark;
      1: b = EndMark;
      2: b = InterruptByte;
      default: begin
        do begin
          b = 8'($urandom_range(0, 255));
          d = hex_digit_value(b);
        end while (d[4]);
      end
    endcase
    return b;
  endfunction

  task automatic add_packet();
    int         len;
    int         kind;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] chk;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
    sum = 8'h00;
    add_byte(StartMark, $urandom_range(0, 29) == 0);
    repeat (len) begin
      case ($urandom_range(0, 15))
        0: b = StartMark;
        1: b = InterruptByte;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (b == EndMark) b = NackByte;
      sum = sum + b;
      add_byte(b);
    end
    add_byte(EndMark);
    kind = $urandom_range(0, 9);
    chk = (kind == 7) ? sum ^ (8'd1 << $urandom_range(0, 7)) : sum;
    add_byte((kind == 8) ? non_hex_char() : hex_char(chk[7:4]));
    add_byte((kind == 9) ? non_hex_char() : hex_char(chk[3:0]));
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 7))
      0: add_byte(InterruptByte);
      1: add_byte(StartMark);
      2: add_byte(EndMark);
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin : drive
    logic took;
    int   outstanding;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        parse_byte(rx_byte_i);
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid_i || took) begin
        outstanding = sent_cnt + int'(took) - recv_cnt;
        if (byte_q.size() != 0 && !(drain_q[0] && outstanding != 0) &&
            $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          in_valid_i <= 1'b1;
          rx_byte_i <= byte_q.pop_front();
          void'(drain_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    rx_result_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        recv_cnt <= recv_cnt + 1;
        if (expected_q.size() == 0) begin
          flag_error($sformatf("result with nothing pending: event %0d", event_res_o));
        end else begin
          e = expected_q.pop_front();
          case (e.ev)
            EV_PAYLOAD: payload_cnt++;
            EV_GOOD: good_cnt++;
            EV_BAD: nack_cnt++;
            EV_INTR: intr_cnt++;
            default: ;
          endcase
          if (event_res_o !== e.ev)
            flag_error($sformatf("event_res exp %0d got %0d", e.ev, event_res_o));
          if (payload_byte_o !== e.payload)
            flag_error($sformatf("payload_byte exp %h got %h", e.payload, payload_byte_o));
          if (sent_sum_o !== e.sent)
            flag_error($sformatf("sent_sum exp %h got %h", e.sent, sent_sum_o));
          if (computed_sum_o !== e.computed)
            flag_error($sformatf("computed_sum exp %h got %h", e.computed, computed_sum_o));
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  initial begin
    int total;
    // hunting: extremes, interrupt, stray end marker
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(InterruptByte);
    add_byte(EndMark);
    // markers inside the body, good checksum 0x26
    add_byte(StartMark);
    add_byte(InterruptByte);
    add_byte(StartMark);
    add_byte(8'hff);
    add_byte(EndMark);
    add_byte(8'h32);
    add_byte(8'h36);
    // mixed case digits, good checksum 0xfa
    add_byte(StartMark);
    add_byte(8'hfa);
    add_byte(EndMark);
    add_byte(8'h66);
    add_byte(8'h41);
    // non-hex first digit, sums otherwise match
    add_byte(StartMark);
    add_byte(8'h01);
    add_byte(EndMark);
    add_byte(8'h47);
    add_byte(8'h31);
    // empty body, non-hex second digit
    add_byte(StartMark);
    add_byte(EndMark);
    add_byte(8'h39);
    add_byte(InterruptByte);
    add_byte(8'h5a, 1'b1);
    while (byte_q.size() < NumBytes) begin
      if ($urandom_range(0, 9) < 7) add_packet();
      else repeat ($urandom_range(1, 4)) add_noise();
    end
    total = byte_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cnt < total || recv_cnt < total) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_q.size() != 0) flag_error("results still missing at end of run");

    $display("Covered %0d bytes: %0d payload, %0d good packets, %0d nacks, %0d interrupts",
             total, payload_cnt, good_cnt, nack_cnt, intr_cnt);
    $display("Mismatches: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("debug_packet_receiver_core verification clean");
    end else begin
      $display("debug_packet_receiver_core verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d of the results received", recv_cnt);
    $display("debug_packet_receiver_core verification failed");
    $finish;
  end

endmodule
